[design/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared widths, token and status codes, and divider request/response types
// for the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;

	localparam int DataW = 32;
	localparam int ReqW  = 3;
	localparam int StatW = 3;

	// token codes
	localparam logic [ReqW-1:0] REQ_PUSH = 3'd0;
	localparam logic [ReqW-1:0] REQ_ADD  = 3'd1;
	localparam logic [ReqW-1:0] REQ_SUB  = 3'd2;
	localparam logic [ReqW-1:0] REQ_MUL  = 3'd3;
	localparam logic [ReqW-1:0] REQ_DIV  = 3'd4;
	localparam logic [ReqW-1:0] REQ_END  = 3'd5;

	// status codes
	localparam logic [StatW-1:0] STAT_OK    = 3'd0;
	localparam logic [StatW-1:0] STAT_FEW   = 3'd1;
	localparam logic [StatW-1:0] STAT_DIV0  = 3'd2;
	localparam logic [StatW-1:0] STAT_FULL  = 3'd3;
	localparam logic [StatW-1:0] STAT_EMPTY = 3'd4;

	typedef struct packed {
		logic             start;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DataW-1:0] quotient;
	} div_rsp_t;

endpackage

[design/rpn_ram.sv]
// ----------------------------------------------------------------------------
// rpn_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/rpn_div.sv]
// ----------------------------------------------------------------------------
// rpn_div
// Iterative radix-2 signed divider, one quotient bit per cycle, truncating
// toward zero. The divisor must be nonzero; INT_MIN / -1 wraps.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int StepW = $clog2(DataW + 1);

	logic             busy_q;
	logic             done_q;
	logic [StepW-1:0] step_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] mb_q;
	logic             neg_q;

	logic [DataW:0]   shifted;
	logic [DataW:0]   trial;

	assign shifted = {rem_q, quo_q[DataW-1]};
	assign trial   = shifted - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(DataW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[DataW-1] ? -req.dividend : req.dividend;
			mb_q  <= req.divisor[DataW-1] ? -req.divisor : req.divisor;
			neg_q <= req.dividend[DataW-1] ^ req.divisor[DataW-1];
		end else if (busy_q) begin
			// restore on borrow, else keep the difference
			rem_q <= trial[DataW] ? shifted[DataW-1:0] : trial[DataW-1:0];
			quo_q <= {quo_q[DataW-2:0], ~trial[DataW]};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -quo_q : quo_q;

endmodule

[design/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse-Polish evaluator on a bounded stack of 32-bit signed integers held
// in a synchronous RAM. Every token request yields one result request.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata            tuser        tlast
//  s_*       in         operand_value    req_type     -
//  m_*       out        value            status       is_final
//
//  Token flow, accept to result: push, too-few, full, end-on-empty and
//  unused-on-empty answer at accept; end and unused codes otherwise make one
//  stack read; add, subtract and divide by zero make two stack reads through
//  the single RAM read port; multiply adds a registered product; divide
//  waits for the 32-step radix-2 divider.
//  Reset clears the stack count and all control state; the stack RAM is not
//  cleared, only entries below the count are ever used.
//  A token is taken only when idle and the result register is empty or is
//  being emptied in the same cycle; a stalled result holds until taken.
//
module rpn_stack_evaluator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [DataW-1:0] s_tdata,   // [31:0] operand_value
	input  logic [ReqW-1:0]  s_tuser,   // [2:0] req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [DataW-1:0] m_tdata,   // [31:0] value
	output logic [StatW-1:0] m_tuser,   // [2:0] status
	output logic             m_tlast    // is_final
);

	localparam int AddrW = $clog2(STACK_DEPTH);
	localparam int CntW  = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SECOND,
		S_OPER,
		S_MUL,
		S_DIV,
		S_PEEK
	} state_t;

	state_t           state_q;
	logic [CntW-1:0]  count_q;
	logic [ReqW-1:0]  req_q;
	logic [DataW-1:0] second_q;
	logic [DataW-1:0] prod_q;

	logic             accept;
	logic             full;
	logic [CntW-1:0]  cnt_m1;
	logic [CntW-1:0]  cnt_m2;
	logic             quick_tok;
	logic             res_load;

	logic             fin_valid;
	logic [DataW-1:0] fin_value;

	logic             ram_we;
	logic [AddrW-1:0] ram_wr_addr;
	logic [DataW-1:0] ram_wr_data;
	logic             ram_rd_en;
	logic [AddrW-1:0] ram_rd_addr;
	logic [DataW-1:0] ram_rd_data;

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CntW'(STACK_DEPTH));
	assign cnt_m1   = count_q - CntW'(1);
	assign cnt_m2   = count_q - CntW'(2);

	// Tokens that answer right at accept, with no stack read to wait for.
	assign quick_tok = (s_tuser == REQ_PUSH) || (count_q == '0) ||
		((count_q == CntW'(1)) && (s_tuser inside {REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV}));

	// A new result request loads the output register this cycle.
	assign res_load = (accept && quick_tok) || (state_q == S_PEEK) ||
		((state_q == S_OPER) && (req_q == REQ_DIV) && (second_q == '0)) || fin_valid;

	// Finished operator: write the result over the first operand.
	always_comb begin
		fin_valid = 1'b0;
		fin_value = prod_q;
		case (state_q)
			S_OPER: begin
				fin_valid = (req_q == REQ_ADD) || (req_q == REQ_SUB);
				fin_value = (req_q == REQ_ADD) ? ram_rd_data + second_q
				                               : ram_rd_data - second_q;
			end
			S_MUL: begin
				fin_valid = 1'b1;
				fin_value = prod_q;
			end
			S_DIV: begin
				fin_valid = div_rsp.done;
				fin_value = div_rsp.quotient;
			end
			default: begin
				fin_valid = 1'b0;
			end
		endcase
	end

	// Stack RAM ports: write pushes and finished results; read the top on accept, the element below it next.
	always_comb begin
		ram_we      = fin_valid || (accept && (s_tuser == REQ_PUSH) && !full);
		ram_wr_addr = fin_valid ? cnt_m2[AddrW-1:0] : count_q[AddrW-1:0];
		ram_wr_data = fin_valid ? fin_value : s_tdata;
		ram_rd_en   = accept || (state_q == S_SECOND);
		ram_rd_addr = (state_q == S_SECOND) ? cnt_m2[AddrW-1:0] : cnt_m1[AddrW-1:0];
	end

	assign div_req.start    = (state_q == S_OPER) && (req_q == REQ_DIV) && (second_q != '0);
	assign div_req.dividend = ram_rd_data;
	assign div_req.divisor  = second_q;

	rpn_ram #(
		.Width (DataW),
		.Depth (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	rpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, stack count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			req_q    <= REQ_PUSH;
			second_q <= '0;
			prod_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= STAT_OK;
			m_tlast  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads below
			if (m_tvalid && m_tready && !res_load) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= s_tuser;
						case (s_tuser)
							REQ_PUSH: begin
								m_tvalid <= 1'b1;
								m_tlast  <= 1'b0;
								if (full) begin
									count_q <= '0;
									m_tdata <= '0;
									m_tuser <= STAT_FULL;
								end else begin
									count_q <= count_q + CntW'(1);
									m_tdata <= s_tdata;
									m_tuser <= STAT_OK;
								end
							end
							REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
								if (count_q < CntW'(2)) begin
									count_q  <= '0;
									m_tvalid <= 1'b1;
									m_tdata  <= '0;
									m_tuser  <= STAT_FEW;
									m_tlast  <= 1'b0;
								end else begin
									state_q <= S_SECOND;
								end
							end
							REQ_END: begin
								if (count_q == '0) begin
									m_tvalid <= 1'b1;
									m_tdata  <= '0;
									m_tuser  <= STAT_EMPTY;
									m_tlast  <= 1'b1;
								end else begin
									// pop now; the read already addresses the old top
									count_q <= cnt_m1;
									state_q <= S_PEEK;
								end
							end
							default: begin
								// unused code: report the top, leave the stack alone
								if (count_q == '0) begin
									m_tvalid <= 1'b1;
									m_tdata  <= '0;
									m_tuser  <= STAT_OK;
									m_tlast  <= 1'b0;
								end else begin
									state_q <= S_PEEK;
								end
							end
						endcase
					end
				end
				S_SECOND: begin
					second_q <= ram_rd_data;
					state_q  <= S_OPER;
				end
				S_OPER: begin
					case (req_q)
						REQ_MUL: begin
							prod_q  <= ram_rd_data * second_q;
							state_q <= S_MUL;
						end
						REQ_DIV: begin
							if (second_q == '0) begin
								count_q  <= '0;
								m_tvalid <= 1'b1;
								m_tdata  <= '0;
								m_tuser  <= STAT_DIV0;
								m_tlast  <= 1'b0;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_DIV;
							end
						end
						default: begin
							// add and subtract finish here
						end
					endcase
				end
				S_PEEK: begin
					m_tvalid <= 1'b1;
					m_tdata  <= ram_rd_data;
					m_tuser  <= STAT_OK;
					m_tlast  <= (req_q == REQ_END);
					state_q  <= S_IDLE;
				end
				default: begin
					// multiply and divide wait for the finish strobe below
				end
			endcase
			if (fin_valid) begin
				count_q  <= cnt_m1;
				m_tvalid <= 1'b1;
				m_tdata  <= fin_value;
				m_tuser  <= STAT_OK;
				m_tlast  <= 1'b0;
				state_q  <= S_IDLE;
			end
		end
	end

	// the stack count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(STACK_DEPTH))
		else $error("stack count above depth");

	// an operator result never lands on a result that is still pending
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> !m_tvalid)
		else $error("operator result overwrites pending result");

	// an operator only finishes with two operands on the stack
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> (count_q >= CntW'(2)))
		else $error("operator finished with fewer than two operands");

	// a push always answers in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == REQ_PUSH)) |=> m_tvalid)
		else $error("push produced no result");

endmodule

[tb/tb_rpn_stack_evaluator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_evaluator
// Self-checking bench for the RPN stack evaluator. A driver feeds token
// requests from a queue, and a monitor checks every result request against
// a local evaluation stack. The run steps through several idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator;
	import rpn_pkg::*;

	localparam int Depth      = STACK_DEPTH_DEF;
	localparam int CycleLimit = 600000;
	localparam int PrintLimit = 40;

	// unused codes: the evaluator reports the top and leaves the stack alone
	localparam logic [ReqW-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [ReqW-1:0] REQ_SPARE_B = 3'd7;

	localparam logic [DataW-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [DataW-1:0] WORD_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [ReqW-1:0]  kind;
		logic [DataW-1:0] operand;
	} token_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic [StatW-1:0] status;
		logic             is_final;
	} result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [DataW-1:0] s_tdata = '0;   // [31:0] operand_value
	logic [ReqW-1:0]  s_tuser = '0;   // [2:0] req_type
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [DataW-1:0] m_tdata;        // [31:0] value
	logic [StatW-1:0] m_tuser;        // [2:0] status
	logic             m_tlast;        // is_final

	token_t  pending_tokens[$];
	result_t expected_results[$];

	logic [DataW-1:0] eval_stack [Depth];
	int eval_depth = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit token_taken = 1'b0;
	int cycle_count = 0;
	int fail_count = 0;
	int tokens_queued = 0;
	int tokens_accepted = 0;
	int results_checked = 0;
	int status_seen [8];

	rpn_stack_evaluator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
	end

	// Apply one token to the local stack and return the result it causes.
	function automatic result_t eval_token(input token_t t);
		result_t r;
		logic [DataW-1:0] lhs, rhs, res, mag_l, mag_r, quo;
		logic div_zero;
		r = '0;
		res = '0;
		div_zero = 1'b0;
		case (t.kind)
			REQ_PUSH: begin
				if (eval_depth >= Depth) begin
					eval_depth = 0;
					r.status = STAT_FULL;
				end else begin
					eval_stack[eval_depth] = t.operand;
					eval_depth++;
					r.value = t.operand;
				end
			end
			REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
				if (eval_depth < 2) begin
					eval_depth = 0;
					r.status = STAT_FEW;
				end else begin
					rhs = eval_stack[eval_depth-1];
					lhs = eval_stack[eval_depth-2];
					case (t.kind)
						REQ_ADD: res = lhs + rhs;
						REQ_SUB: res = lhs - rhs;
						REQ_MUL: res = lhs * rhs;
						default: begin
							if (rhs == '0) begin
								div_zero = 1'b1;
							end else begin
								// divide magnitudes, then fix the sign (truncates toward zero)
								mag_l = lhs[DataW-1] ? -lhs : lhs;
								mag_r = rhs[DataW-1] ? -rhs : rhs;
								quo = mag_l / mag_r;
								res = (lhs[DataW-1] ^ rhs[DataW-1]) ? -quo : quo;
							end
						end
					endcase
					if (div_zero) begin
						eval_depth = 0;
						r.status = STAT_DIV0;
					end else begin
						eval_depth--;
						eval_stack[eval_depth-1] = res;
						r.value = res;
					end
				end
			end
			REQ_END: begin
				r.is_final = 1'b1;
				if (eval_depth == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					eval_depth--;
					r.value = eval_stack[eval_depth];
				end
			end
			default: begin
				// ignored code: report the top without touching the stack
				if (eval_depth > 0)
					r.value = eval_stack[eval_depth-1];
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
			input logic [DataW-1:0] want);
		if (fail_count < PrintLimit)
			$display("%0t ns: MISMATCH %s: got 0x%08h, want 0x%08h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result request with no token outstanding", m_tdata, '0);
		end else begin
			want = expected_results.pop_front();
			if (m_tdata !== want.value)
				report_mismatch("value", m_tdata, want.value);
			if (m_tuser !== want.status)
				report_mismatch("status", DataW'(m_tuser), DataW'(want.status));
			if (m_tlast !== want.is_final)
				report_mismatch("is_final", DataW'(m_tlast), DataW'(want.is_final));
			status_seen[m_tuser]++;
			results_checked++;
		end
	endtask

	// Monitor: check the result first, since a token accepted at the same
	// edge is always younger than that result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready) begin
				expected_results.push_back(eval_token(pending_tokens.pop_front()));
				token_taken = 1'b1;
				tokens_accepted++;
			end
		end
	end

	// Driver: hold an offered token until it is taken, then maybe idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!(s_tvalid && !token_taken)) begin
				if (pending_tokens.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_tokens[0].operand;
					s_tuser  <= pending_tokens[0].kind;
				end else begin
					s_tvalid <= 1'b0;
					s_tdata  <= $urandom;
					s_tuser  <= 3'($urandom_range(7));
				end
			end
			token_taken = 1'b0;
		end
	end

	task automatic add_token(input logic [ReqW-1:0] kind, input logic [DataW-1:0] operand);
		token_t t;
		t.kind = kind;
		t.operand = operand;
		pending_tokens.push_back(t);
		if (kind <= REQ_END)
			tokens_queued++;
	endtask

	function automatic logic [DataW-1:0] pick_value();
		logic [DataW-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = 32'd1;
			2: v = '1;
			3: v = WORD_MIN;
			4: v = WORD_MAX;
			5, 6: begin
				v = $urandom_range(40);
				v = v - 32'd20;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [ReqW-1:0] pick_op();
		case ($urandom_range(3))
			0: return REQ_ADD;
			1: return REQ_SUB;
			2: return REQ_MUL;
			default: return REQ_DIV;
		endcase
	endfunction

	// Well-formed expression: pushes and operators that reduce to one value,
	// then an end token that pops it.
	task automatic gen_expression();
		int pushes_left, live;
		pushes_left = $urandom_range(2, 8);
		live = 0;
		while (pushes_left > 0 || live > 1) begin
			if (pushes_left > 0 && (live < 2 || $urandom_range(1) == 1)) begin
				add_token(REQ_PUSH, pick_value());
				live++;
				pushes_left--;
			end else begin
				add_token(pick_op(), $urandom);
				live--;
			end
		end
		add_token(REQ_END, $urandom);
	endtask

	// Overfill: one push past the depth always hits the full error,
	// whatever was left on the stack.
	task automatic gen_overfill();
		for (int i = 0; i <= Depth; i++)
			add_token(REQ_PUSH, pick_value());
	endtask

	task automatic gen_noise();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			add_token(3'($urandom_range(7)), pick_value());
	endtask

	task automatic gen_random(input int budget);
		int stop_at, pick;
		stop_at = tokens_queued + budget;
		while (tokens_queued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 72)
				gen_expression();
			else if (pick < 74)
				gen_overfill();
			else
				gen_noise();
		end
	endtask

	task automatic wait_drained();
		while (pending_tokens.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		// start from an empty stack after the overfill, fill it to the top
		// and fold it down to a single value
		gen_overfill();
		for (int i = 0; i < Depth; i++)
			add_token(REQ_PUSH, $urandom);
		for (int i = 1; i < Depth; i++)
			add_token(($urandom_range(1) == 1) ? REQ_ADD : REQ_MUL, $urandom);
		add_token(REQ_END, $urandom);
	end

	initial begin : stimulus
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// end and operator on an empty stack
		add_token(REQ_END, $urandom);
		add_token(REQ_ADD, $urandom);
		// add wraps from the largest value to the smallest
		add_token(REQ_PUSH, WORD_MAX);
		add_token(REQ_PUSH, 32'd1);
		add_token(REQ_ADD, '0);
		// smallest value over minus one wraps back to itself
		add_token(REQ_PUSH, '1);
		add_token(REQ_DIV, '1);
		add_token(REQ_PUSH, 32'd3);
		add_token(REQ_MUL, '0);
		add_token(REQ_PUSH, 32'd7);
		add_token(REQ_SUB, '0);
		// mixed-sign divide truncates toward zero
		add_token(REQ_PUSH, 32'hFFFF_FFFE);
		add_token(REQ_DIV, '0);
		add_token(REQ_SPARE_A, WORD_MAX);
		add_token(REQ_END, '0);
		add_token(REQ_SPARE_B, WORD_MIN);
		add_token(REQ_PUSH, 32'hFFFF_FFF9);
		add_token(REQ_PUSH, 32'd2);
		add_token(REQ_DIV, '0);
		// zero divisor clears the stack, so the end that follows finds it empty
		add_token(REQ_PUSH, '0);
		add_token(REQ_DIV, '0);
		add_token(REQ_END, '0);
		// operator with a single entry
		add_token(REQ_PUSH, 32'd5);
		add_token(REQ_SUB, '0);
		wait_drained();

		// idle patterns: none, sender only, receiver only, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			// hold the sender mid-phase until every result is back
			gen_random(130);
			wait_drained();
			gen_random(130);
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never returned", DataW'(expected_results.size()), '0);

		$display("%0d token requests accepted over %0d cycles, %0d results checked",
			tokens_accepted, cycle_count, results_checked);
		$display("status mix: ok %0d, too few %0d, div by zero %0d, full %0d, empty %0d",
			status_seen[STAT_OK], status_seen[STAT_FEW], status_seen[STAT_DIV0],
			status_seen[STAT_FULL], status_seen[STAT_EMPTY]);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < CycleLimit)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_results.size());
		$display("simulation failed");
		$finish;
	end

endmodule

[rpn_stack_evaluator.f]
design/rpn_pkg.sv
design/rpn_ram.sv
design/rpn_div.sv
design/rpn_stack_evaluator.sv
tb/tb_rpn_stack_evaluator.sv
